/* src/evtmr_pkg.sv */
// ----------------------------------------------------------------------------
// Event timer package
// Shared codes, register layout constants and the command/status structs
// passed between the timer top level and its comparator slices.
// ----------------------------------------------------------------------------
package evtmr_pkg;

   localparam int DATA_W     = 64;
   localparam int ADDR_W     = 7;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CAP_MASK_W = 3;   // width of the capability masks
   localparam int OUT_MASK_W = 3;   // width of the line and message masks
   localparam int CTRL_W     = 16;
   localparam int SLOT_W     = 5;

   // Item commands.
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   // Word addresses of the register map.
   localparam logic [ADDR_W-1:0] WA_CAPS     = 7'd0;
   localparam logic [ADDR_W-1:0] WA_GEN_CFG  = 7'd2;
   localparam logic [ADDR_W-1:0] WA_STATUS   = 7'd4;
   localparam logic [ADDR_W-1:0] WA_COUNTER  = 7'd30;
   localparam logic [SLOT_W-1:0] SLOT_OFFSET = 5'd8;   // word 32 in units of four

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VENDOR       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REVISION     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC_CAP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MESSAGE_CAP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUTE_CAP    = 3'd5;

   // Comparator configuration word bit positions.
   localparam int CFG_LEVEL_BIT  = 1;
   localparam int CFG_ENABLE_BIT = 2;
   localparam int CFG_PERIOD_BIT = 3;
   localparam int CFG_PCAP_BIT   = 4;
   localparam int CFG_WIDE_BIT   = 5;
   localparam int CFG_VALSET_BIT = 6;
   localparam int CFG_MSG_BIT    = 14;
   localparam int CFG_MCAP_BIT   = 15;
   localparam logic [CTRL_W-1:0] CFG_RW_MASK = 16'h7E4E;

   // Register within a comparator's group of four words.
   typedef enum logic [1:0] {
      KIND_CFG   = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_ROUTE = 2'd2,
      KIND_NONE  = 2'd3
   } evtmr_kind_type;

   typedef struct packed {
      logic              write;   // accepted write item
      logic              tick;    // accepted tick while counting runs
      evtmr_kind_type    kind;
      logic [DATA_W-1:0] data;
   } evtmr_cmd_type;

   typedef struct packed {
      logic edge_hit;    // edge-mode line pulse on this tick
      logic fire_hit;    // message sent on this tick
      logic level_set;   // level-mode status bit to set
      logic line_gate;   // level mode, enabled, not messaging, after update
   } evtmr_status_type;

endpackage

/* src/event_timer_block_registers.sv */
// ----------------------------------------------------------------------------
// Event timer block
// 64-bit main counter with NUM_COMPARATORS comparators behind a 64-bit
// register map; items are register reads, register writes or counter ticks.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the req_ channel (command, word address, write data) and
// each gives exactly one result on the rsp_ channel: read data, the level of
// the comparator interrupt lines and the message pulses of that item.
// Each item updates all state and the result register in the cycle it is
// accepted. Throughput is one item per cycle while the receiver does not
// stall; the limit is the single pass through the counter increment, the
// parallel compares and the periodic adders. When the receiver stalls, the
// result register holds, and req_stall is raised only while a held result is
// still waiting; a new item is taken in the same cycle the waiting result
// leaves. Reset clears the counter, control and status, sets every compare
// value to all ones and loads the capability registers with their defaults.
// The user must write the capability registers over the csr_ port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module event_timer_block_registers import evtmr_pkg::*; #(
   parameter int NUM_COMPARATORS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [ADDR_W-1:0]     req_word_address,
   input  logic [DATA_W-1:0]     req_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_read_data,
   output logic [OUT_MASK_W-1:0] rsp_line_irq_mask,
   output logic [OUT_MASK_W-1:0] rsp_message_fire_mask,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IdxW  = (NUM_COMPARATORS > 1) ? $clog2(NUM_COMPARATORS) : 1;
   localparam int MaskW = (NUM_COMPARATORS > OUT_MASK_W) ? NUM_COMPARATORS : OUT_MASK_W;

   // Capability registers.
   logic [26:0]           tick_period_ff;
   logic [15:0]           vendor_ff;
   logic [7:0]            revision_ff;
   logic [CAP_MASK_W-1:0] periodic_cap_ff;
   logic [CAP_MASK_W-1:0] message_cap_ff;
   logic [CSR_DATA_W-1:0] route_cap_ff;

   // Block state.
   logic [DATA_W-1:0]          count_ff, count_in;
   logic [1:0]                 gen_cfg_ff, gen_cfg_in;
   logic [NUM_COMPARATORS-1:0] pending_ff, pending_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_read_data_ff, rsp_read_data_in;
   logic [OUT_MASK_W-1:0] rsp_line_ff, rsp_line_in;
   logic [OUT_MASK_W-1:0] rsp_fire_ff, rsp_fire_in;

   logic                       accept;
   logic                       is_read;
   logic                       is_write;
   logic                       is_tick;
   logic [DATA_W-1:0]          next_count;
   logic [SLOT_W-1:0]          slot;
   logic                       cmp_space;
   logic                       slot_ok;
   logic [IdxW-1:0]            rd_idx;
   evtmr_kind_type             kind;
   evtmr_cmd_type              cmd;
   logic [NUM_COMPARATORS-1:0] select;
   logic [NUM_COMPARATORS-1:0] per_cap;
   logic [NUM_COMPARATORS-1:0] msg_cap;
   logic [DATA_W-1:0]          cfg_rd   [NUM_COMPARATORS];
   logic [DATA_W-1:0]          value_rd [NUM_COMPARATORS];
   logic [DATA_W-1:0]          route_rd [NUM_COMPARATORS];
   evtmr_status_type           status   [NUM_COMPARATORS];
   logic [NUM_COMPARATORS-1:0] edge_vec;
   logic [NUM_COMPARATORS-1:0] fire_vec;
   logic [NUM_COMPARATORS-1:0] level_set_vec;
   logic [NUM_COMPARATORS-1:0] gate_vec;
   logic [MaskW-1:0]           line_wide;
   logic [MaskW-1:0]           fire_wide;
   logic [DATA_W-1:0]          caps_word;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      is_read  = 1'b0;
      is_write = 1'b0;
      is_tick  = 1'b0;
      unique case (req_command)
         CMD_READ:  is_read  = accept;
         CMD_WRITE: is_write = accept;
         CMD_TICK:  is_tick  = accept & gen_cfg_ff[0];
         default: begin
         end
      endcase
   end

   // Comparator words start at 32, four words per comparator.
   assign slot      = req_word_address[ADDR_W-1:2] - SLOT_OFFSET;
   assign cmp_space = req_word_address[6] | req_word_address[5];
   assign slot_ok   = cmp_space && (6'(slot) < 6'(NUM_COMPARATORS));
   assign rd_idx    = slot[IdxW-1:0];
   assign kind      = evtmr_kind_type'(req_word_address[1:0]);
   assign next_count = count_ff + 64'd1;

   assign cmd.write = is_write;
   assign cmd.tick  = is_tick;
   assign cmd.kind  = kind;
   assign cmd.data  = req_write_data;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_COMPARATORS; gi++) begin : g_cmp
         assign select[gi] = slot_ok && (slot == SLOT_W'(gi));
         if (gi < CAP_MASK_W) begin : g_cap
            assign per_cap[gi] = periodic_cap_ff[gi];
            assign msg_cap[gi] = message_cap_ff[gi];
         end else begin : g_nocap
            assign per_cap[gi] = 1'b0;
            assign msg_cap[gi] = 1'b0;
         end

         evtmr_comparator u_comparator (
            .clock        (clock),
            .reset        (reset),
            .cmd          (cmd),
            .select       (select[gi]),
            .next_count   (next_count),
            .periodic_cap (per_cap[gi]),
            .message_cap  (msg_cap[gi]),
            .route_cap    (route_cap_ff),
            .cfg_rd       (cfg_rd[gi]),
            .value_rd     (value_rd[gi]),
            .route_rd     (route_rd[gi]),
            .status       (status[gi])
         );

         assign edge_vec[gi]      = status[gi].edge_hit;
         assign fire_vec[gi]      = status[gi].fire_hit;
         assign level_set_vec[gi] = status[gi].level_set;
         assign gate_vec[gi]      = status[gi].line_gate;
      end
   endgenerate

   // Counter, general configuration and interrupt status.
   always_comb begin
      count_in   = count_ff;
      gen_cfg_in = gen_cfg_ff;
      pending_in = pending_ff;
      if (is_write) begin
         if (req_word_address == WA_GEN_CFG) begin
            gen_cfg_in = req_write_data[1:0];
         end
         if (req_word_address == WA_STATUS) begin
            pending_in = pending_ff & ~req_write_data[NUM_COMPARATORS-1:0];
         end
         if (req_word_address == WA_COUNTER) begin
            count_in = req_write_data;
         end
      end else if (is_tick) begin
         count_in   = next_count;
         pending_in = pending_ff | level_set_vec;
      end
   end

   assign caps_word = {5'd0, tick_period_ff, vendor_ff, 1'b1, 1'b0, 1'b1,
                       5'(NUM_COMPARATORS - 1), revision_ff};

   always_comb begin
      rsp_read_data_in = '0;
      if (is_read) begin
         if (req_word_address == WA_CAPS) begin
            rsp_read_data_in = caps_word;
         end else if (req_word_address == WA_GEN_CFG) begin
            rsp_read_data_in = DATA_W'(gen_cfg_ff);
         end else if (req_word_address == WA_STATUS) begin
            rsp_read_data_in = DATA_W'(pending_ff);
         end else if (req_word_address == WA_COUNTER) begin
            rsp_read_data_in = count_ff;
         end else if (slot_ok) begin
            unique case (kind)
               KIND_CFG:   rsp_read_data_in = cfg_rd[rd_idx];
               KIND_VALUE: rsp_read_data_in = value_rd[rd_idx];
               KIND_ROUTE: rsp_read_data_in = route_rd[rd_idx];
               default:    rsp_read_data_in = '0;
            endcase
         end
      end
   end

   // Line levels come from the state as it stands after this item.
   assign line_wide   = MaskW'((gate_vec & pending_in) | edge_vec);
   assign fire_wide   = MaskW'(fire_vec);
   assign rsp_line_in = line_wide[OUT_MASK_W-1:0];
   assign rsp_fire_in = fire_wide[OUT_MASK_W-1:0];

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         gen_cfg_ff   <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         gen_cfg_ff   <= gen_cfg_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_line_ff      <= rsp_line_in;
         rsp_fire_ff      <= rsp_fire_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff  <= 27'd69841279;
         vendor_ff       <= 16'd32902;
         revision_ff     <= 8'd1;
         periodic_cap_ff <= 3'd1;
         message_cap_ff  <= 3'd0;
         route_cap_ff    <= 32'd4194304;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TICK_PERIOD:  tick_period_ff  <= csr_write_data[26:0];
            CSR_VENDOR:       vendor_ff       <= csr_write_data[15:0];
            CSR_REVISION:     revision_ff     <= csr_write_data[7:0];
            CSR_PERIODIC_CAP: periodic_cap_ff <= csr_write_data[CAP_MASK_W-1:0];
            CSR_MESSAGE_CAP:  message_cap_ff  <= csr_write_data[CAP_MASK_W-1:0];
            CSR_ROUTE_CAP:    route_cap_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_read_data_ff;
   assign rsp_line_irq_mask     = rsp_line_ff;
   assign rsp_message_fire_mask = rsp_fire_ff;

endmodule

/* src/evtmr_comparator.sv */
// ----------------------------------------------------------------------------
// Event timer comparator
// One comparator: configuration word, compare value, period and message
// route, with the match check against the incremented main counter.
// ----------------------------------------------------------------------------
module evtmr_comparator import evtmr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  evtmr_cmd_type         cmd,
   input  logic                  select,
   input  logic [DATA_W-1:0]     next_count,
   input  logic                  periodic_cap,
   input  logic                  message_cap,
   input  logic [CSR_DATA_W-1:0] route_cap,
   output logic [DATA_W-1:0]     cfg_rd,
   output logic [DATA_W-1:0]     value_rd,
   output logic [DATA_W-1:0]     route_rd,
   output evtmr_status_type      status
);

   logic [CTRL_W-1:0] ctrl_ff, ctrl_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] period_ff, period_in;
   logic [DATA_W-1:0] route_ff, route_in;
   logic [CTRL_W-1:0] cfg_low;
   logic              match;
   logic              msg_now;
   logic              hit;

   assign match   = (next_count == value_ff);
   assign msg_now = ctrl_ff[CFG_MSG_BIT] & message_cap;
   assign hit     = cmd.tick & match & ctrl_ff[CFG_ENABLE_BIT];

   always_comb begin
      ctrl_in   = ctrl_ff;
      value_in  = value_ff;
      period_in = period_ff;
      route_in  = route_ff;
      if (cmd.write && select) begin
         unique case (cmd.kind)
            KIND_CFG: begin
               ctrl_in = cmd.data[CTRL_W-1:0] & CFG_RW_MASK;
               if (!periodic_cap) ctrl_in[CFG_PERIOD_BIT] = 1'b0;
               if (!message_cap) ctrl_in[CFG_MSG_BIT] = 1'b0;
            end
            KIND_VALUE: begin
               // A periodic comparator takes a new compare value only after
               // software has set the value-set bit; the period always loads.
               if (!ctrl_ff[CFG_PERIOD_BIT] || ctrl_ff[CFG_VALSET_BIT]) begin
                  value_in = cmd.data;
               end
               period_in = cmd.data;
               ctrl_in[CFG_VALSET_BIT] = 1'b0;
            end
            KIND_ROUTE: begin
               route_in = cmd.data;
            end
            default: begin
            end
         endcase
      end else if (cmd.tick && match && ctrl_ff[CFG_PERIOD_BIT]) begin
         value_in = value_ff + period_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= '0;
         value_ff  <= '1;
         period_ff <= '0;
         route_ff  <= '0;
      end else begin
         ctrl_ff   <= ctrl_in;
         value_ff  <= value_in;
         period_ff <= period_in;
         route_ff  <= route_in;
      end
   end

   always_comb begin
      cfg_low = ctrl_ff & CFG_RW_MASK;
      cfg_low[CFG_PCAP_BIT] = periodic_cap;
      cfg_low[CFG_WIDE_BIT] = 1'b1;
      cfg_low[CFG_MCAP_BIT] = message_cap;
   end

   assign cfg_rd   = {route_cap, 16'd0, cfg_low};
   assign value_rd = value_ff;
   assign route_rd = route_ff;

   assign status.fire_hit  = hit & msg_now;
   assign status.level_set = hit & ~msg_now & ctrl_ff[CFG_LEVEL_BIT];
   assign status.edge_hit  = hit & ~msg_now & ~ctrl_ff[CFG_LEVEL_BIT];
   assign status.line_gate = ctrl_in[CFG_LEVEL_BIT] & ctrl_in[CFG_ENABLE_BIT]
                             & ~(ctrl_in[CFG_MSG_BIT] & message_cap);

endmodule

/* src/evtmr_checker.sv */
// ----------------------------------------------------------------------------
// Event timer port checker
// Watches the ports of the timer block and checks result flow and the
// result fields that depend on the kind of item.
// ----------------------------------------------------------------------------
module evtmr_checker import evtmr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [CMD_W-1:0]      req_command,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DATA_W-1:0]     rsp_read_data,
   input logic [OUT_MASK_W-1:0] rsp_message_fire_mask
);

   // The input side only waits while a result is held.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // Every accepted item shows a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no result");

   // Only a read returns data.
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command != CMD_READ) |=> rsp_read_data == '0)
      else $error("read data nonzero for a write or tick item");

   // Messages are sent only on ticks.
   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command != CMD_TICK)
      |=> rsp_message_fire_mask == '0)
      else $error("message fired on an item that is not a tick");

   // A stalled result holds.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_data)))
      else $error("stalled result changed");

endmodule

bind event_timer_block_registers evtmr_checker u_evtmr_checker (.*);

/* verif/event_timer_block_registers_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event timer block testbench
// Sends register reads, register writes and counter ticks, runs an item-level
// model of the counter, comparators and register map beside the block, and
// checks every result against it. Capability settings change between phases.
// ----------------------------------------------------------------------------
module event_timer_block_registers_tb;
   import evtmr_pkg::*;

   localparam int NUM_COMPARATORS = 3;
   localparam int RANDOM_ITEMS    = 1950;
   localparam int LONG_HOLD       = 64;
   localparam int IDLE_SETTLE     = 3;
   localparam int DRAIN_LIMIT     = 2000;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [CTRL_W-1:0] CTL_LEVEL  = CTRL_W'(1) << CFG_LEVEL_BIT;
   localparam logic [CTRL_W-1:0] CTL_ENABLE = CTRL_W'(1) << CFG_ENABLE_BIT;
   localparam logic [CTRL_W-1:0] CTL_PERIOD = CTRL_W'(1) << CFG_PERIOD_BIT;
   localparam logic [CTRL_W-1:0] CTL_VALSET = CTRL_W'(1) << CFG_VALSET_BIT;
   localparam logic [CTRL_W-1:0] CTL_MSG    = CTRL_W'(1) << CFG_MSG_BIT;

   localparam logic [26:0] DEF_PERIOD_FS = 27'd69841279;
   localparam logic [15:0] DEF_VENDOR    = 16'd32902;
   localparam logic [7:0]  DEF_REVISION  = 8'd1;
   localparam logic [2:0]  DEF_PER_CAP   = 3'd1;
   localparam logic [2:0]  DEF_MSG_CAP   = 3'd0;
   localparam logic [31:0] DEF_ROUTE_CAP = 32'd4194304;

   typedef struct packed {
      logic [DATA_W-1:0]     read_data;
      logic [OUT_MASK_W-1:0] line_mask;
      logic [OUT_MASK_W-1:0] fire_mask;
   } timer_response_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command = CMD_READ;
   logic [ADDR_W-1:0]     req_word_address = '0;
   logic [DATA_W-1:0]     req_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DATA_W-1:0]     rsp_read_data;
   logic [OUT_MASK_W-1:0] rsp_line_irq_mask;
   logic [OUT_MASK_W-1:0] rsp_message_fire_mask;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TICK_PERIOD;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   event_timer_block_registers #(.NUM_COMPARATORS(NUM_COMPARATORS)) dut (.*);

   // Model state of the timer and its capability settings.
   logic [26:0]       cfg_period_fs;
   logic [15:0]       cfg_vendor;
   logic [7:0]        cfg_revision;
   logic [2:0]        cfg_periodic_cap;
   logic [2:0]        cfg_message_cap;
   logic [31:0]       cfg_route_cap;
   logic [63:0]       counter_now;
   logic [1:0]        run_control;
   logic [2:0]        model_status;
   logic [CTRL_W-1:0] slot_control [NUM_COMPARATORS];
   logic [63:0]       slot_compare [NUM_COMPARATORS];
   logic [63:0]       slot_period  [NUM_COMPARATORS];
   logic [63:0]       slot_route   [NUM_COMPARATORS];

   timer_response_type pending_responses [$];
   timer_response_type oldest_response;
   int mismatches = 0;
   int items_sent = 0;
   logic sender_gaps_on = 1'b1;
   logic receiver_stalls_on = 1'b1;
   logic hold_off_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void load_timer_defaults();
      cfg_period_fs    = DEF_PERIOD_FS;
      cfg_vendor       = DEF_VENDOR;
      cfg_revision     = DEF_REVISION;
      cfg_periodic_cap = DEF_PER_CAP;
      cfg_message_cap  = DEF_MSG_CAP;
      cfg_route_cap    = DEF_ROUTE_CAP;
      counter_now  = '0;
      run_control  = '0;
      model_status = '0;
      for (int i = 0; i < NUM_COMPARATORS; i++) begin
         slot_control[i] = '0;
         slot_compare[i] = '1;
         slot_period[i]  = '0;
         slot_route[i]   = '0;
      end
   endfunction

   function automatic logic [63:0] comparator_word(int i);
      logic [63:0] v;
      v = 64'(slot_control[i] & CFG_RW_MASK);
      v[CFG_PCAP_BIT] = cfg_periodic_cap[i];
      v[CFG_WIDE_BIT] = 1'b1;
      v[CFG_MCAP_BIT] = cfg_message_cap[i];
      v[63:32] = cfg_route_cap;
      return v;
   endfunction

   // Applies one item to the model and returns the result it must produce.
   function automatic timer_response_type next_timer_response(
      logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      timer_response_type r;
      logic [OUT_MASK_W-1:0] edge_hits;
      logic [CTRL_W-1:0] ctl;
      logic msg;
      logic slot_hit;
      int idx;
      evtmr_kind_type kind;
      r = '0;
      edge_hits = '0;
      idx = int'(addr[6:2]) - int'(SLOT_OFFSET);
      slot_hit = idx >= 0 && idx < NUM_COMPARATORS;
      kind = evtmr_kind_type'(addr[1:0]);
      case (cmd)
         CMD_READ: begin
            if (addr == WA_CAPS)
               r.read_data = {5'b0, cfg_period_fs, cfg_vendor, 1'b1, 1'b0, 1'b1,
                              5'(NUM_COMPARATORS - 1), cfg_revision};
            else if (addr == WA_GEN_CFG) r.read_data = 64'(run_control);
            else if (addr == WA_STATUS) r.read_data = 64'(model_status);
            else if (addr == WA_COUNTER) r.read_data = counter_now;
            else if (slot_hit) begin
               case (kind)
                  KIND_CFG:   r.read_data = comparator_word(idx);
                  KIND_VALUE: r.read_data = slot_compare[idx];
                  KIND_ROUTE: r.read_data = slot_route[idx];
                  default:    r.read_data = '0;
               endcase
            end
         end
         CMD_WRITE: begin
            if (addr == WA_GEN_CFG) run_control = data[1:0];
            else if (addr == WA_STATUS) model_status = model_status & ~data[2:0];
            else if (addr == WA_COUNTER) counter_now = data;
            else if (slot_hit) begin
               case (kind)
                  KIND_CFG: begin
                     ctl = data[CTRL_W-1:0] & CFG_RW_MASK;
                     if (!cfg_periodic_cap[idx]) ctl[CFG_PERIOD_BIT] = 1'b0;
                     if (!cfg_message_cap[idx]) ctl[CFG_MSG_BIT] = 1'b0;
                     slot_control[idx] = ctl;
                  end
                  KIND_VALUE: begin
                     ctl = slot_control[idx];
                     // A periodic comparator only takes a new compare value
                     // while value-set is armed; the period always updates.
                     if (!ctl[CFG_PERIOD_BIT] || ctl[CFG_VALSET_BIT])
                        slot_compare[idx] = data;
                     slot_period[idx] = data;
                     slot_control[idx][CFG_VALSET_BIT] = 1'b0;
                  end
                  KIND_ROUTE: slot_route[idx] = data;
                  default: ;
               endcase
            end
         end
         CMD_TICK: begin
            if (run_control[0]) begin
               counter_now = counter_now + 64'd1;
               for (int i = 0; i < NUM_COMPARATORS; i++) begin
                  if (counter_now == slot_compare[i]) begin
                     ctl = slot_control[i];
                     if (ctl[CFG_PERIOD_BIT]) slot_compare[i] = slot_compare[i] + slot_period[i];
                     msg = ctl[CFG_MSG_BIT] && cfg_message_cap[i];
                     if (ctl[CFG_ENABLE_BIT]) begin
                        if (msg) r.fire_mask[i] = 1'b1;
                        else if (ctl[CFG_LEVEL_BIT]) model_status[i] = 1'b1;
                        else edge_hits[i] = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_COMPARATORS; i++) begin
         ctl = slot_control[i];
         msg = ctl[CFG_MSG_BIT] && cfg_message_cap[i];
         if (ctl[CFG_LEVEL_BIT] && ctl[CFG_ENABLE_BIT] && !msg && model_status[i])
            r.line_mask[i] = 1'b1;
      end
      r.line_mask = r.line_mask | edge_hits;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_address(int i, evtmr_kind_type kind);
      return {SLOT_OFFSET + 5'(i), kind};
   endfunction

   function automatic logic [ADDR_W-1:0] pick_register_address();
      case ($urandom_range(0, 6))
         0: return WA_CAPS;
         1: return WA_GEN_CFG;
         2: return WA_STATUS;
         3: return WA_COUNTER;
         default: return slot_address($urandom_range(0, NUM_COMPARATORS - 1),
                                      evtmr_kind_type'($urandom_range(0, 3)));
      endcase
   endfunction

   function automatic void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 100)
         $error("%s: expected %h, got %h", field, want, got);
   endfunction

   // Result checker: compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            mismatches++;
            $error("result with no item outstanding");
         end else begin
            oldest_response = pending_responses.pop_front();
            if (rsp_read_data !== oldest_response.read_data)
               report_mismatch("read_data", oldest_response.read_data, rsp_read_data);
            if (rsp_line_irq_mask !== oldest_response.line_mask)
               report_mismatch("line_irq_mask", 64'(oldest_response.line_mask),
                               64'(rsp_line_irq_mask));
            if (rsp_message_fire_mask !== oldest_response.fire_mask)
               report_mismatch("message_fire_mask", 64'(oldest_response.fire_mask),
                               64'(rsp_message_fire_mask));
         end
      end
   end

   // Receiver pacing, including the long hold-off that backs up the block.
   initial begin : receiver_pacing
      int hold;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = receiver_stalls_on ? pick_gap() : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      int gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_word_address <= addr;
      req_write_data   <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_responses.push_back(next_timer_response(cmd, addr, data));
      items_sent++;
   endtask

   task automatic tick();
      send_item(CMD_TICK, 7'($urandom), {$urandom, $urandom});
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_responses.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [26:0] period_fs, input logic [15:0] vendor,
                                 input logic [7:0] revision, input logic [2:0] per_cap,
                                 input logic [2:0] msg_cap, input logic [31:0] route_cap);
      wait_idle();
      write_setting(CSR_TICK_PERIOD, 32'(period_fs));
      write_setting(CSR_VENDOR, 32'(vendor));
      write_setting(CSR_REVISION, 32'(revision));
      write_setting(CSR_PERIODIC_CAP, 32'(per_cap));
      write_setting(CSR_MESSAGE_CAP, 32'(msg_cap));
      write_setting(CSR_ROUTE_CAP, route_cap);
      csr_write_enable <= 1'b0;
      cfg_period_fs    = period_fs;
      cfg_vendor       = vendor;
      cfg_revision     = revision;
      cfg_periodic_cap = per_cap;
      cfg_message_cap  = msg_cap;
      cfg_route_cap    = route_cap;
      @(posedge clock);
   endtask

   task automatic test_reset_values();
      send_item(CMD_READ, WA_CAPS, '0);
      send_item(CMD_READ, WA_GEN_CFG, '0);
      send_item(CMD_READ, WA_STATUS, '0);
      send_item(CMD_READ, WA_COUNTER, '0);
      send_item(CMD_READ, slot_address(0, KIND_CFG), '0);
      send_item(CMD_READ, slot_address(1, KIND_VALUE), '0);
      send_item(CMD_READ, slot_address(2, KIND_ROUTE), '0);
      send_item(CMD_READ, slot_address(0, KIND_NONE), '0);
      send_item(CMD_READ, slot_address(NUM_COMPARATORS, KIND_CFG), '0);
      send_item(CMD_READ, 7'd1, '0);
      // The capability word is read-only and unknown words ignore writes.
      send_item(CMD_WRITE, WA_CAPS, '1);
      send_item(CMD_WRITE, 7'd127, '1);
      send_item(CMD_READ, 7'd127, '0);
      send_item(CMD_READ, WA_CAPS, '0);
   endtask

   task automatic test_setting_extremes();
      apply_settings(27'd1000001, 16'd0, 8'd1, 3'd0, 3'd0, 32'd0);
      send_item(CMD_READ, WA_CAPS, '0);
      send_item(CMD_READ, slot_address(1, KIND_CFG), '0);
      apply_settings(27'd100000000, 16'hFFFF, 8'd255, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_item(CMD_READ, WA_CAPS, '0);
      send_item(CMD_READ, slot_address(2, KIND_CFG), '0);
   endtask

   task automatic test_message_delivery();
      send_item(CMD_WRITE, slot_address(2, KIND_CFG), 64'(CTL_ENABLE | CTL_MSG | CTL_LEVEL));
      send_item(CMD_WRITE, slot_address(2, KIND_ROUTE), 64'hFEE0_0000_DEAD_BEEF);
      send_item(CMD_WRITE, slot_address(2, KIND_VALUE), 64'd2);
      send_item(CMD_WRITE, WA_GEN_CFG, 64'd1);
      repeat (3) tick();
      send_item(CMD_READ, slot_address(2, KIND_ROUTE), '0);
      send_item(CMD_READ, slot_address(2, KIND_CFG), '0);
   endtask

   task automatic test_comparator_modes();
      apply_settings(DEF_PERIOD_FS, DEF_VENDOR, DEF_REVISION, DEF_PER_CAP, DEF_MSG_CAP,
                     DEF_ROUTE_CAP);
      send_item(CMD_WRITE, WA_GEN_CFG, 64'd3);
      send_item(CMD_READ, WA_GEN_CFG, '0);
      send_item(CMD_WRITE, slot_address(0, KIND_CFG),
                64'(CTL_LEVEL | CTL_ENABLE | CTL_PERIOD | CTL_VALSET));
      send_item(CMD_WRITE, slot_address(0, KIND_VALUE), 64'd5);
      // Value-set is spent, so this write only changes the period.
      send_item(CMD_WRITE, slot_address(0, KIND_VALUE), 64'd7);
      send_item(CMD_READ, slot_address(0, KIND_VALUE), '0);
      // Comparator 1 cannot run periodic here, so that bit is dropped.
      send_item(CMD_WRITE, slot_address(1, KIND_CFG), 64'(CTL_ENABLE | CTL_PERIOD));
      send_item(CMD_WRITE, slot_address(1, KIND_VALUE), 64'd6);
      send_item(CMD_WRITE, WA_COUNTER, 64'd3);
      repeat (4) tick();
      send_item(CMD_READ, WA_STATUS, '0);
      send_item(CMD_WRITE, WA_STATUS, '1);
      send_item(CMD_WRITE, WA_GEN_CFG, 64'd0);
      tick();
      send_item(CMD_READ, WA_COUNTER, '0);
      // Zero period: the compare value stays put and matches again after wrap.
      send_item(CMD_WRITE, slot_address(0, KIND_CFG), 64'(CTL_ENABLE | CTL_PERIOD | CTL_VALSET));
      send_item(CMD_WRITE, slot_address(0, KIND_VALUE), 64'd0);
      send_item(CMD_WRITE, WA_COUNTER, ~64'd1);
      send_item(CMD_WRITE, WA_GEN_CFG, 64'd1);
      repeat (3) tick();
      send_item(CMD_READ, slot_address(0, KIND_VALUE), '0);
      send_item(CMD_UNUSED, WA_CAPS, '1);
   endtask

   task automatic test_backpressure();
      sender_gaps_on = 1'b0;
      hold_off_request = 1'b1;
      for (int k = 0; k < 40; k++) begin
         if (k % 4 == 3) send_item(CMD_READ, WA_COUNTER, '0);
         else tick();
      end
      sender_gaps_on = 1'b1;
   endtask

   // Loads the counter and writes every comparator a compare value a few ticks ahead of it.
   task automatic arm_comparators();
      logic [63:0] base;
      logic [CTRL_W-1:0] ctl;
      if ($urandom_range(0, 3) == 0) base = ~64'd0 - 64'($urandom_range(0, 30));
      else base = {$urandom, $urandom};
      send_item(CMD_WRITE, WA_COUNTER, base);
      for (int i = 0; i < NUM_COMPARATORS; i++) begin
         ctl = CTRL_W'($urandom);
         ctl[CFG_ENABLE_BIT] = $urandom_range(0, 4) != 0;
         ctl[CFG_VALSET_BIT] = $urandom_range(0, 3) != 0;
         send_item(CMD_WRITE, slot_address(i, KIND_CFG), {$urandom, 16'($urandom), ctl});
         send_item(CMD_WRITE, slot_address(i, KIND_VALUE), base + 64'($urandom_range(1, 25)));
         if ($urandom_range(0, 1) == 1)
            send_item(CMD_WRITE, slot_address(i, KIND_VALUE), 64'($urandom_range(0, 12)));
         if ($urandom_range(0, 3) == 0)
            send_item(CMD_WRITE, slot_address(i, KIND_ROUTE), {$urandom, $urandom});
      end
      send_item(CMD_WRITE, WA_GEN_CFG, {$urandom, 31'($urandom), 1'b1});
   endtask

   task automatic random_burst(input int count);
      int r;
      int i;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         i = $urandom_range(0, NUM_COMPARATORS - 1);
         if (r < 55) tick();
         else if (r < 70) send_item(CMD_READ, pick_register_address(), {$urandom, $urandom});
         else if (r < 78) send_item(CMD_WRITE, WA_STATUS, {$urandom, $urandom});
         else if (r < 83) send_item(CMD_READ, 7'($urandom), {$urandom, $urandom});
         else if (r < 87) send_item(CMD_WRITE, 7'($urandom), {$urandom, $urandom});
         else if (r < 91) send_item(CMD_UNUSED, 7'($urandom), {$urandom, $urandom});
         else if (r < 96)
            send_item(CMD_WRITE, slot_address(i, KIND_VALUE),
                      counter_now + 64'($urandom_range(1, 10)));
         else send_item(CMD_WRITE, slot_address(i, KIND_CFG), {$urandom, $urandom});
      end
   endtask

   task automatic test_random_traffic(input int target);
      int stop_at;
      int round;
      stop_at = items_sent + target;
      round = 0;
      while (items_sent < stop_at) begin
         if (round % 10 == 5) begin
            case ($urandom_range(0, 3))
               0: apply_settings(27'd1000001, 16'd0, 8'd1, 3'd0, 3'd0, 32'd0);
               1: apply_settings(27'd100000000, 16'hFFFF, 8'd255, 3'd7, 3'd7, 32'hFFFF_FFFF);
               default: apply_settings(27'($urandom_range(1000001, 100000000)),
                                       16'($urandom), 8'($urandom_range(1, 255)),
                                       3'($urandom), 3'($urandom), $urandom);
            endcase
         end
         sender_gaps_on = $urandom_range(0, 3) != 0;
         receiver_stalls_on = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 9) < 8) arm_comparators();
         random_burst($urandom_range(20, 60));
         round++;
      end
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
   endtask

   initial begin
      load_timer_defaults();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_setting_extremes();
      test_message_delivery();
      test_comparator_modes();
      test_backpressure();
      test_random_traffic(RANDOM_ITEMS);
      wait_idle();
      if (pending_responses.size() != 0) begin
         mismatches++;
         $error("%0d results never arrived", pending_responses.size());
      end
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* event_timer_block_registers.f */
src/evtmr_pkg.sv
src/evtmr_comparator.sv
src/event_timer_block_registers.sv
src/evtmr_checker.sv
verif/event_timer_block_registers_tb.sv
